FILE: sv/packed_list_table_engine_defines.svh
// assertion macros used by the bound checker
`ifndef PACKED_LIST_TABLE_ENGINE_DEFINES_SVH
`define PACKED_LIST_TABLE_ENGINE_DEFINES_SVH

// clocked property, ignored while reset is held
`define PLTE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, with the reset input named rst_n in the enclosing scope
`define PLTE_ASSERT_RST(lbl, prop, msg) \
  `PLTE_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

FILE: sv/plte_pkg.sv
`default_nettype none
package plte_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int VAL_W       = 32;
  localparam int POS_W       = 6;
  localparam int OUT_CNT_W   = 7;

  // stream packing
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 48;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             found;
    logic [CNT_W-1:0] entry_count;
    status_t          status;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/packed_list_table_engine.sv
// channel | ports                          | contents
// in      | in_tvalid/in_tready/in_tdata   | tdata: value, position; tuser: opcode
// out     | out_tvalid/out_tready/out_tdata| tdata: read_value, found, entry_count, status
//
// append writes the ram as it is accepted; read issues the ram read at accept, then takes the data.
// remove and query scan the list through the single-port-read ram, one entry per
// cycle, until every entry below the count has been compared.
// rst_n (synchronous) empties the list; no clearing pass, entries are read only below the count.
// a finished word waits in the output register while the next word is accepted.
`default_nettype none
module packed_list_table_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // value[31:0], position[37:32], zero pad
  input  wire logic [plte_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // read_value[31:0], found[32], entry_count[39:33], status[41:40], zero pad
  output logic [plte_pkg::OUT_DATA_W-1:0]        out_tdata
);
  import plte_pkg::*;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;
  logic             res_valid, res_ready;
  res_t             res;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  plte_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (VAL_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  plte_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (opcode_t'(in_tuser)),
    .in_value (in_tdata[VAL_W-1:0]),
    .in_pos   (in_tdata[VAL_W +: POS_W]),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= {(OUT_DATA_W - VAL_W - 1 - OUT_CNT_W - 2)'(0), res.status,
                     OUT_CNT_W'(res.entry_count), res.found, res.read_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

FILE: sv/plte_ram.sv
`default_nettype none
module plte_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/plte_seq.sv
`default_nettype none
module plte_seq (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire plte_pkg::opcode_t        in_op,
  input  wire logic [plte_pkg::VAL_W-1:0] in_value,
  input  wire logic [plte_pkg::POS_W-1:0] in_pos,
  output logic                          ram_we,
  output logic [plte_pkg::IDX_W-1:0]    ram_waddr,
  output logic [plte_pkg::VAL_W-1:0]    ram_wdata,
  output logic                          ram_re,
  output logic [plte_pkg::IDX_W-1:0]    ram_raddr,
  input  wire logic [plte_pkg::VAL_W-1:0] ram_rdata,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output plte_pkg::res_t                res
);
  import plte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] wr_r, wr_nxt;
  logic             pend_r, pend_nxt;
  logic             hit_r, hit_nxt;
  opcode_t          op_r, op_nxt;
  logic [VAL_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] rv_r, rv_nxt;
  status_t          st_r, st_nxt;
  logic             more;

  assign more = (rd_r < occ_r);

  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    pend_nxt  = pend_r;
    hit_nxt   = hit_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    rv_nxt    = rv_r;
    st_nxt    = st_r;
    ram_we    = 1'b0;
    ram_waddr = wr_r[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = rd_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          key_nxt  = in_value;
          rv_nxt   = '0;
          hit_nxt  = 1'b0;
          st_nxt   = ST_OK;
          rd_nxt   = '0;
          wr_nxt   = '0;
          pend_nxt = 1'b0;
          case (in_op)
            OP_APPEND: begin
              if (occ_r == CNT_W'(MAX_ENTRIES)) begin
                st_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = occ_r[IDX_W-1:0];
                ram_wdata = in_value;
                occ_nxt   = occ_r + CNT_W'(1);
              end
              state_nxt = S_DONE;
            end
            OP_READ: begin
              if (CNT_W'(in_pos) < occ_r) begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(in_pos);
                pend_nxt  = 1'b1;
                state_nxt = S_SCAN;
              end else begin
                st_nxt    = ST_RANGE;
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (op_r == OP_READ) begin
          rv_nxt    = ram_rdata;
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          // one read issued per cycle, compare lags by the ram latency
          if (more) begin
            ram_re   = 1'b1;
            rd_nxt   = rd_r + CNT_W'(1);
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
          end
          if (pend_r) begin
            if (ram_rdata == key_r) begin
              hit_nxt = 1'b1;
            end else if (op_r == OP_REMOVE) begin
              // compaction write trails the read pointer, no overlap
              ram_we = 1'b1;
              wr_nxt = wr_r + CNT_W'(1);
            end
          end
          if (!more && !pend_r) begin
            if (op_r == OP_REMOVE) begin
              occ_nxt = wr_r;
            end
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r  <= rd_nxt;
    wr_r  <= wr_nxt;
    hit_r <= hit_nxt;
    op_r  <= op_nxt;
    key_r <= key_nxt;
    rv_r  <= rv_nxt;
    st_r  <= st_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_DONE);
  assign res.read_value  = rv_r;
  assign res.found       = hit_r;
  assign res.entry_count = occ_r;
  assign res.status      = st_r;

endmodule
`default_nettype wire

FILE: sv/plte_checker.sv
`default_nettype none
`include "packed_list_table_engine_defines.svh"
module plte_sva (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [plte_pkg::OUT_DATA_W-1:0] out_tdata
);
  import plte_pkg::*;

  logic [OUT_CNT_W-1:0] cnt;
  logic [1:0]           st;
  logic                 fnd;
  logic [VAL_W-1:0]     rv;

  assign rv  = out_tdata[VAL_W-1:0];
  assign fnd = out_tdata[VAL_W];
  assign cnt = out_tdata[VAL_W+1 +: OUT_CNT_W];
  assign st  = out_tdata[VAL_W+1+OUT_CNT_W +: 2];

  // one word at a time on the input side
  `PLTE_ASSERT_RST(a_in_busy, in_tvalid && in_tready |=> !in_tready, "word taken while busy")
  // a stalled result word stays up
  `PLTE_ASSERT_RST(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result word dropped")
  // count never exceeds the table size
  `PLTE_ASSERT_RST(a_cnt_max, out_tvalid |-> cnt <= OUT_CNT_W'(MAX_ENTRIES), "count too large")
  // full status only when the table is full
  `PLTE_ASSERT_RST(a_full_cnt, out_tvalid && st == ST_FULL |-> cnt == OUT_CNT_W'(MAX_ENTRIES),
                   "full status with room left")
  // out of range read returns nothing
  `PLTE_ASSERT_RST(a_range_zero, out_tvalid && st == ST_RANGE |-> rv == '0 && !fnd,
                   "range error with payload")

endmodule

bind packed_list_table_engine plte_sva u_plte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
`default_nettype wire

FILE: test/plte_checker.sv
`timescale 1ns / 100ps
module plte_checker
  import plte_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]            in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  output int                         words_due,
  output int                         error_total
);

  logic [VAL_W-1:0] list_mem [MAX_ENTRIES];
  int unsigned      list_len;
  res_t             due_q [$];
  int               errs;

  // shadow of the packed list, one word in, one word out
  function automatic res_t list_apply(opcode_t op, logic [VAL_W-1:0] val,
                                      logic [POS_W-1:0] pos);
    res_t        r;
    int unsigned keep;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (list_len >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        // compact in place, order of survivors kept
        keep = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            r.found = 1'b1;
          end else begin
            list_mem[keep] = list_mem[i];
            keep++;
          end
        end
        list_len = keep;
      end
      OP_READ: begin
        if (pos < list_len) r.read_value = list_mem[pos];
        else r.status = ST_RANGE;
      end
      default: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) r.found = 1'b1;
        end
      end
    endcase
    r.entry_count = list_len[CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      list_len = 0;
      due_q.delete();
      errs = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_value  = out_tdata[31:0];
        got.found       = out_tdata[32];
        got.entry_count = out_tdata[39:33];
        got.status      = status_t'(out_tdata[41:40]);
        if (due_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected word, expected none, got %0h", $time, out_tdata);
        end else begin
          want = due_q.pop_front();
          check_field("read_value", want.read_value, got.read_value);
          check_field("found", 32'(want.found), 32'(got.found));
          check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
          check_field("status", 32'(want.status), 32'(got.status));
        end
      end
      if (in_tvalid && in_tready) begin
        due_q.push_back(list_apply(opcode_t'(in_tuser), in_tdata[VAL_W-1:0],
                                   in_tdata[VAL_W+POS_W-1:VAL_W]));
      end
    end
    words_due   <= due_q.size();
    error_total <= errs;
  end

endmodule

FILE: test/tb_packed_list_table_engine.sv
`timescale 1ns / 100ps
module tb_packed_list_table_engine;
  import plte_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 11;
  localparam int PHASE_WORDS = 100;
  localparam int POOL        = 12;

  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_EVEN,
    MIX_SHRINK
  } mix_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  steady     = 1'b0;
  int                    words_due;
  int                    error_total;
  int                    cycles     = 0;
  logic [VAL_W-1:0]      pool [POOL];

  packed_list_table_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  plte_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .words_due  (words_due),
    .error_total(error_total)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= steady || ($urandom_range(99) >= 33);
  end

  task automatic send_word(opcode_t op, logic [VAL_W-1:0] val, logic [POS_W-1:0] pos);
    while (!steady && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-VAL_W-POS_W){1'b0}}, pos, val};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold the sender off until every word in flight has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  // mostly values from a small pool so removes and queries hit
  function automatic logic [VAL_W-1:0] pick_value(int pool_pct);
    if ($urandom_range(99) < pool_pct) return pool[$urandom_range(POOL-1)];
    return $urandom();
  endfunction

  task automatic random_word(mix_t mix);
    int               r;
    opcode_t          op;
    logic [POS_W-1:0] pos;
    r = $urandom_range(99);
    if (mix == MIX_GROW) begin
      if (r < 85) op = OP_APPEND;
      else if (r < 95) op = OP_READ;
      else op = OP_QUERY;
    end else if (mix == MIX_SHRINK) begin
      if (r < 45) op = OP_REMOVE;
      else if (r < 70) op = OP_APPEND;
      else if (r < 85) op = OP_READ;
      else op = OP_QUERY;
    end else begin
      if (r < 25) op = OP_APPEND;
      else if (r < 50) op = OP_REMOVE;
      else if (r < 75) op = OP_READ;
      else op = OP_QUERY;
    end
    if ($urandom_range(1)) pos = POS_W'($urandom_range(63));
    else pos = POS_W'($urandom_range(15));
    send_word(op, pick_value(op == OP_APPEND ? 70 : 80), pos);
  endtask

  initial begin
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'hffff_fc19;
    pool[3] = 32'h0000_0000;
    for (int i = 4; i < POOL; i++) pool[i] = $urandom();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: read past the end, query and remove with no match
    send_word(OP_READ, 32'h0, 6'd0);
    send_word(OP_QUERY, 32'h8000_0000, 6'd0);
    send_word(OP_REMOVE, 32'h5, 6'd0);
    // extremes, the old empty marker and duplicates are ordinary values
    send_word(OP_APPEND, 32'h8000_0000, 6'd0);
    send_word(OP_APPEND, 32'h7fff_ffff, 6'd0);
    send_word(OP_APPEND, 32'hffff_fc19, 6'd0);
    send_word(OP_APPEND, 32'h0, 6'd0);
    send_word(OP_APPEND, 32'hffff_ffff, 6'd0);
    send_word(OP_APPEND, 32'h8000_0000, 6'd0);
    send_word(OP_READ, 32'h0, 6'd0);
    send_word(OP_READ, 32'h0, 6'd5);
    send_word(OP_READ, 32'h0, 6'd6);
    send_word(OP_READ, 32'h0, 6'd63);
    send_word(OP_QUERY, 32'h7fff_ffff, 6'd0);
    send_word(OP_QUERY, 32'd12345, 6'd0);
    send_word(OP_QUERY, 32'hffff_fc19, 6'd0);
    // both copies go, survivors shift down
    send_word(OP_REMOVE, 32'h8000_0000, 6'd0);
    send_word(OP_READ, 32'h0, 6'd0);
    send_word(OP_READ, 32'h0, 6'd3);
    send_word(OP_REMOVE, 32'd777, 6'd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      steady <= (p == 4);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        random_word(p % 3 == 0 ? MIX_GROW : (p % 3 == 1 ? MIX_EVEN : MIX_SHRINK));
      end
      if (p % 4 == 3) drain();
    end
    steady <= 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (error_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
